// ----- src/empirical_cdf_sampler_unit_assert.svh -----
// Assertion macros shared by the sampler unit
`ifndef EMPIRICAL_CDF_SAMPLER_UNIT_ASSERT_SVH
`define EMPIRICAL_CDF_SAMPLER_UNIT_ASSERT_SVH

// implication in the same cycle
`define ECS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define ECS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ecs_pkg.sv -----
`timescale 1ns / 1ps
package ecs_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_MEAN   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [23:0] ONE_Q16 = 24'd65536;
    localparam int          NUM_W   = 56;
    localparam int          PROD_W  = 57;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic        rem_nz;
    } t_div_res;

endpackage

// ----- src/ecs_divider.sv -----
`timescale 1ns / 1ps
module ecs_divider import ecs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [23:0]      i_den,
    output t_div_res         o_res
);

    logic             r_busy;
    logic [5:0]       r_cnt;
    logic [23:0]      r_rem;
    logic [NUM_W-1:0] r_q;
    logic [23:0]      r_den;
    logic             r_done;

    logic [24:0] w_sh;
    logic [24:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_q[NUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[23:0] : w_sh[23:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_q[31:0];
    assign o_res.rem_nz = |r_rem;

endmodule

// ----- src/ecs_table.sv -----
`timescale 1ns / 1ps
module ecs_table import ecs_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wvalue,
    input  logic [23:0]   i_wcdf,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rvalue,
    output logic [23:0]   o_rcdf
);

    logic [31:0] r_values [DEPTH];
    logic [23:0] r_cdfs   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_values[i_waddr] <= i_wvalue;
            r_cdfs[i_waddr]   <= i_wcdf;
        end
        o_rvalue <= r_values[i_raddr];
        o_rcdf   <= r_cdfs[i_raddr];
    end

endmodule

// ----- src/empirical_cdf_sampler_unit.sv -----
`timescale 1ns / 1ps
// Empirical CDF sampler: clear and load go straight to the result state. A sample walks the
// table entries with one table read plus one compare per entry walked, and where it
// interpolates it then does the interpolation multiply and the 56-step divider; a mean
// takes a read, compare, shared multiplier and accumulate step per entry. The
// table has a single-port read and the one multiplier is shared; the input is
// not ready while a command is in progress.
module empirical_cdf_sampler_unit import ecs_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_entry_value,
    input  logic [23:0] i_entry_cdf,
    input  logic [16:0] i_uniform,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status
);

`include "empirical_cdf_sampler_unit_assert.svh"

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ACC_W = 59 + $clog2(TABLE_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MULX = 11'b00000000010,
        S_RD   = 11'b00000000100,
        S_CHK  = 11'b00000001000,
        S_IMUL = 11'b00000010000,
        S_DST  = 11'b00000100000,
        S_DIV  = 11'b00001000000,
        S_MMUL = 11'b00010000000,
        S_MACC = 11'b00100000000,
        S_MFIN = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [23:0]         r_high;
    logic [1:0]          r_cmd;
    logic [16:0]         r_u;
    logic [CW-1:0]       r_idx, n_idx;
    logic [31:0]         r_pv, n_pv;
    logic [23:0]         r_pc, n_pc;
    logic [23:0]         r_dx, n_dx;
    logic [23:0]         r_den, n_den;
    logic [31:0]         r_dy, n_dy;
    logic                r_neg, n_neg;
    logic [32:0]         r_sv, n_sv;
    logic [23:0]         r_dcm, n_dcm;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [31:0]         r_res, n_res;
    logic [1:0]          r_stat, n_stat;
    logic                r_ovalid;
    logic [31:0]         r_oval;
    logic [1:0]          r_ostat;

    logic              w_accept;
    logic              w_full;
    logic              w_last;
    logic [23:0]       w_x;
    logic [32:0]       w_mul_a;
    logic [23:0]       w_mul_b;
    logic              w_mul_en;
    logic [31:0]       w_rvalue;
    logic [23:0]       w_rcdf;
    logic              w_div_start;
    t_div_res          w_div;
    logic [ACC_W-1:0]  w_ext;
    logic [32:0]       w_mid;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CW'(TABLE_DEPTH));
    assign w_last   = (r_idx == r_count - CW'(1));
    assign w_x      = r_prod[39:16];
    assign w_ext    = {{(ACC_W - PROD_W){1'b0}}, r_prod};
    assign w_mid    = {1'b0, r_pv} + {1'b0, w_rvalue};
    assign w_div_start = (r_state == S_DST);

    ecs_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .i_clk    (i_clk),
        .i_we     (w_accept && (i_cmd == CMD_LOAD) && !w_full),
        .i_waddr  (r_count[AW-1:0]),
        .i_wvalue (i_entry_value),
        .i_wcdf   (i_entry_cdf),
        .i_raddr  (r_idx[AW-1:0]),
        .o_rvalue (w_rvalue),
        .o_rcdf   (w_rcdf)
    );

    ecs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod[NUM_W-1:0]),
        .i_den   (r_den),
        .o_res   (w_div)
    );

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        unique case (r_state)
            S_MULX: begin
                w_mul_a  = {16'd0, r_u};
                w_mul_b  = r_high;
                w_mul_en = 1'b1;
            end
            S_IMUL: begin
                w_mul_a  = {1'b0, r_dy};
                w_mul_b  = r_dx;
                w_mul_en = 1'b1;
            end
            S_MMUL: begin
                w_mul_a  = r_sv;
                w_mul_b  = r_dcm;
                w_mul_en = 1'b1;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pv    = r_pv;
        n_pc    = r_pc;
        n_dx    = r_dx;
        n_den   = r_den;
        n_dy    = r_dy;
        n_neg   = r_neg;
        n_sv    = r_sv;
        n_dcm   = r_dcm;
        n_acc   = r_acc;
        n_res   = r_res;
        n_stat  = r_stat;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res  = '0;
                    n_stat = ST_OK;
                    n_idx  = '0;
                    n_pv   = '0;
                    n_pc   = '0;
                    n_acc  = '0;
                    n_state = S_DONE;
                    if (i_cmd == CMD_LOAD && w_full) begin
                        n_stat = ST_FULL;
                    end else if (i_cmd == CMD_SAMPLE || i_cmd == CMD_MEAN) begin
                        if (r_count == '0) begin
                            n_stat = ST_EMPTY;
                        end else if (i_cmd == CMD_SAMPLE) begin
                            n_state = S_MULX;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_MULX: n_state = S_RD;
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (r_cmd == CMD_SAMPLE) begin
                    if (w_x <= w_rcdf) begin
                        if (r_pc == w_rcdf) begin
                            n_res   = w_mid[32:1];
                            n_state = S_DONE;
                        end else begin
                            n_dx  = w_x - r_pc;
                            n_den = w_rcdf - r_pc;
                            n_neg = (w_rvalue < r_pv);
                            n_dy  = n_neg ? (r_pv - w_rvalue) : (w_rvalue - r_pv);
                            n_state = S_IMUL;
                        end
                    end else if (w_last) begin
                        n_res   = w_rvalue;
                        n_state = S_DONE;
                    end else begin
                        n_pv    = w_rvalue;
                        n_pc    = w_rcdf;
                        n_idx   = r_idx + CW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    n_sv  = w_mid;
                    n_neg = (w_rcdf < r_pc);
                    n_dcm = n_neg ? (r_pc - w_rcdf) : (w_rcdf - r_pc);
                    n_pv  = w_rvalue;
                    n_pc  = w_rcdf;
                    n_state = S_MMUL;
                end
            end
            S_IMUL: n_state = S_DST;
            S_DST:  n_state = S_DIV;
            S_DIV: begin
                if (w_div.done) begin
                    n_res = r_neg ? (r_pv - w_div.quot - {31'd0, w_div.rem_nz})
                                  : (r_pv + w_div.quot);
                    n_state = S_DONE;
                end
            end
            S_MMUL: n_state = S_MACC;
            S_MACC: begin
                n_acc = r_neg ? (r_acc - w_ext) : (r_acc + w_ext);
                n_idx = r_idx + CW'(1);
                n_state = w_last ? S_MFIN : S_RD;
            end
            S_MFIN: begin
                if (r_acc[ACC_W-1]) begin
                    n_res = '0;
                end else if (|r_acc[ACC_W-2:49]) begin
                    n_res = '1;
                end else begin
                    n_res = r_acc[48:17];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_high   <= ONE_Q16;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (i_cmd == CMD_CLEAR) begin
                    r_count <= '0;
                    r_high  <= ONE_Q16;
                end else if (i_cmd == CMD_LOAD && !w_full) begin
                    r_count <= r_count + CW'(1);
                    if (i_entry_cdf > r_high) begin
                        r_high <= i_entry_cdf;
                    end
                end
            end
            if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_u   <= (i_uniform > 17'd65536) ? 17'd65536 : i_uniform;
        end
        r_idx  <= n_idx;
        r_pv   <= n_pv;
        r_pc   <= n_pc;
        r_dx   <= n_dx;
        r_den  <= n_den;
        r_dy   <= n_dy;
        r_neg  <= n_neg;
        r_sv   <= n_sv;
        r_dcm  <= n_dcm;
        r_acc  <= n_acc;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (w_mul_en) begin
            r_prod <= {{(PROD_W - 33){1'b0}}, w_mul_a} * {{(PROD_W - 24){1'b0}}, w_mul_b};
        end
        if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
            r_oval  <= r_res;
            r_ostat <= r_stat;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_status       = r_ostat;

    `ECS_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n,
        w_accept && (i_cmd == CMD_LOAD) && w_full,
        (r_state == S_DONE) && (r_stat == ST_FULL) && $stable(r_count),
        "dropped load did not flag full")
    `ECS_ASSERT_NOW(a_div_state, i_clk, i_rst_n,
        w_div.done, r_state == S_DIV,
        "divider finished outside the divide step")
    `ECS_ASSERT_NOW(a_high_floor, i_clk, i_rst_n,
        1'b1, (r_high >= ONE_Q16) && (r_count <= CW'(TABLE_DEPTH)),
        "highest cdf or entry count out of range")

endmodule

// ----- tb/tb_empirical_cdf_sampler_unit.sv -----
`timescale 1ns / 1ps
module tb_empirical_cdf_sampler_unit;
    import ecs_pkg::*;

    localparam int DEPTH     = 256;
    localparam int LIMIT_CYC = 10000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [23:0] cdf;
        logic [16:0] uniform;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_entry_value = '0;
    logic [23:0] i_entry_cdf = '0;
    logic [16:0] i_uniform = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_value;
    logic [1:0]  o_status;

    empirical_cdf_sampler_unit #(.TABLE_DEPTH(DEPTH)) u_top (.*);

    always #4 i_clk = ~i_clk;

    t_cmd_item   pending_cmds[$];
    t_outcome    expected_outcomes[$];
    logic [31:0] tbl_values[DEPTH];
    logic [23:0] tbl_cdfs[DEPTH];
    int          tbl_count;
    logic [23:0] cdf_lo, cdf_hi;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          stimulus_done = 0;
    int          hold_off = 0;

    function automatic logic [31:0] lerp_value(longint x, longint x1, longint y1,
                                               longint x2, longint y2);
        longint num, q;
        if (x1 == x2) return 32'((y1 + y2) >>> 1);
        num = (x - x1) * (y2 - y1);
        q = num / (x2 - x1);
        if ((num % (x2 - x1)) != 0 && num < 0) q -= 1;
        return 32'(y1 + q);
    endfunction

    function automatic logic [31:0] draw_value(logic [16:0] u_in);
        longint u, x;
        u = (u_in > 17'd65536) ? 65536 : longint'(u_in);
        x = longint'(cdf_lo) + ((u * (longint'(cdf_hi) - longint'(cdf_lo))) >>> 16);
        for (int i = 0; i < tbl_count; i++) begin
            if (x <= longint'(tbl_cdfs[i])) begin
                if (i == 0) return lerp_value(x, 0, 0, tbl_cdfs[0], tbl_values[0]);
                return lerp_value(x, tbl_cdfs[i-1], tbl_values[i-1], tbl_cdfs[i],
                                  tbl_values[i]);
            end
        end
        return tbl_values[tbl_count-1];
    endfunction

    function automatic logic [31:0] table_mean_value();
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < tbl_count; i++) begin
            if (i == 0) acc += 128'(tbl_values[0]) * 128'(tbl_cdfs[0]);
            else acc += (128'(tbl_values[i]) + 128'(tbl_values[i-1])) *
                        (128'(tbl_cdfs[i]) - 128'(tbl_cdfs[i-1]));
        end
        if (acc < 0) return 32'd0;
        acc = acc >>> 17;
        if (acc > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return acc[31:0];
    endfunction

    function automatic t_outcome apply_cmd(t_cmd_item it);
        t_outcome r;
        r = '{value: 32'd0, status: ST_OK};
        case (it.cmd)
            CMD_CLEAR: begin
                tbl_count = 0; cdf_lo = 0; cdf_hi = ONE_Q16;
            end
            CMD_LOAD: begin
                if (tbl_count >= DEPTH) r.status = ST_FULL;
                else begin
                    tbl_values[tbl_count] = it.value;
                    tbl_cdfs[tbl_count] = it.cdf;
                    if (it.cdf < cdf_lo) cdf_lo = it.cdf;
                    if (it.cdf > cdf_hi) cdf_hi = it.cdf;
                    tbl_count++;
                end
            end
            default: begin
                if (tbl_count == 0) r.status = ST_EMPTY;
                else if (it.cmd == CMD_SAMPLE) r.value = draw_value(it.uniform);
                else r.value = table_mean_value();
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic push(logic [1:0] c, logic [31:0] v, logic [23:0] f, logic [16:0] u);
        pending_cmds.push_back('{cmd: c, value: v, cdf: f, uniform: u});
    endtask

    task automatic push_rand_cmd(bit well_formed);
        logic [31:0] v;
        v = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 100000));
        push(2'($urandom_range(0, 3)), v, well_formed ? 24'($urandom_range(0, 70000))
             : 24'($urandom()), 17'($urandom_range(0, 131071)));
    endtask

    // well-formed table: cleared, then non-decreasing cdfs, then samples and means
    task automatic push_table_run();
        int n, c;
        logic [31:0] v;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        c = 0;
        v = $urandom_range(0, 1000);
        push(CMD_CLEAR, $urandom(), 24'($urandom()), 17'($urandom()));
        for (int i = 0; i < n; i++) begin
            c += $urandom_range(0, 65536 / n + 200);
            if ($urandom_range(0, 7) == 0) v = $urandom();
            else v += $urandom_range(0, 5000);
            push(CMD_LOAD, v, 24'(c), 17'($urandom()));
        end
        for (int i = 0; i < $urandom_range(2, 8); i++)
            push(($urandom_range(0, 3) == 0) ? CMD_MEAN : CMD_SAMPLE, $urandom(),
                 24'($urandom()), ($urandom_range(0, 9) == 0) ? 17'($urandom())
                 : 17'($urandom_range(0, 65536)));
    endtask

    initial begin
        push(CMD_SAMPLE, 0, 0, 0);
        push(CMD_MEAN, 0, 0, 0);
        push(CMD_LOAD, 32'd100, 24'd0, 0);
        push(CMD_LOAD, 32'd300, 24'd0, 0);
        push(CMD_LOAD, 32'hFFFF_FFFF, 24'd65536, 0);
        push(CMD_SAMPLE, 0, 0, 17'd0);
        push(CMD_SAMPLE, 0, 0, 17'd32768);
        push(CMD_SAMPLE, 0, 0, 17'd65536);
        push(CMD_SAMPLE, 0, 0, 17'h1FFFF);
        push(CMD_MEAN, 0, 0, 0);
        push(CMD_LOAD, 32'hFFFF_FFFF, 24'hFFFFFF, 0);
        push(CMD_MEAN, 0, 0, 0);
        push(CMD_LOAD, 32'd5, 24'd10, 0);
        push(CMD_SAMPLE, 0, 0, 17'd65536);
        push(CMD_MEAN, 0, 0, 0);
        push(CMD_CLEAR, 32'hFFFF_FFFF, 24'hFFFFFF, 17'h1FFFF);
        push(CMD_LOAD, 32'd50, 24'd40000, 0);
        push(CMD_SAMPLE, 0, 0, 17'd0);
        push(CMD_SAMPLE, 0, 0, 17'd65535);
        push(CMD_CLEAR, 0, 0, 0);
        // fill past the end of the table
        for (int i = 0; i < DEPTH + 2; i++)
            push(CMD_LOAD, $urandom(), 24'(i * 256), 17'($urandom()));
        push(CMD_SAMPLE, 0, 0, 17'd40000);
        push(CMD_MEAN, 0, 0, 0);
        push(CMD_CLEAR, 0, 0, 0);
        while (pending_cmds.size() < 1450) begin
            if ($urandom_range(0, 4) != 0) push_table_run();
            else push_rand_cmd($urandom_range(0, 1));
        end
        stimulus_done = 1;
    end

    initial begin
        tbl_count = 0; cdf_lo = 0; cdf_hi = ONE_Q16;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_outcomes.push_back(apply_cmd(pending_cmds.pop_front()));
                send_gap = gap_len();
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    i_valid <= 1'b1;
                    i_cmd <= pending_cmds[0].cmd;
                    i_entry_value <= pending_cmds[0].value;
                    i_entry_cdf <= pending_cmds[0].cdf;
                    i_uniform <= pending_cmds[0].uniform;
                end else i_valid <= 1'b0;
            end
        end
    end

    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected transfer: value %0d status %0d",
                           o_result_value, o_status);
                    fail_count++;
                end else begin
                    exp_o = expected_outcomes.pop_front();
                    if (o_result_value !== exp_o.value) begin
                        $error("result_value: expected %0d actual %0d",
                               exp_o.value, o_result_value);
                        fail_count++;
                    end
                    if (o_status !== exp_o.status) begin
                        $error("status: expected %0d actual %0d", exp_o.status, o_status);
                        fail_count++;
                    end
                end
            end
            if (cycle_count == 3000) hold_off = 2500;
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYC) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (pending_cmds.size() == 0 && !i_valid && expected_outcomes.size() == 0);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && expected_outcomes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
